@@ rtl/tas_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Target acquisition and track state: shared package
// Field types, register indexes, reset values, class codes and helpers.
// ----------------------------------------------------------------------------
package tas_pkg;

  // Field types.
  typedef logic [2:0]  name_t;
  typedef logic [3:0]  prio_t;
  typedef logic [15:0] dist_t;
  typedef logic [19:0] us_t;
  typedef logic [7:0]  cnt_t;
  typedef logic [5:0]  idx_t;
  typedef logic [1:0]  mode_t;
  typedef logic [1:0]  init_t;
  typedef logic [2:0]  cfg_idx_t;
  typedef logic [19:0] cfg_data_t;

  // Default bound on armors taken per frame.
  localparam int unsigned MaxArmorsPerFrame = 64;

  // Item kinds.
  localparam logic OP_ARMOR     = 1'b0;
  localparam logic OP_FRAME_END = 1'b1;

  // Configuration register indexes.
  localparam cfg_idx_t CFG_ENEMY_COLOR     = 3'd0;
  localparam cfg_idx_t CFG_MIN_DETECT      = 3'd1;
  localparam cfg_idx_t CFG_MAX_MISS        = 3'd2;
  localparam cfg_idx_t CFG_OUTPOST_MISS    = 3'd3;
  localparam cfg_idx_t CFG_GAP_TIMEOUT     = 3'd4;

  // Configuration reset values.
  localparam logic RST_ENEMY_COLOR  = 1'b0;
  localparam cnt_t RST_MIN_DETECT   = 8'd3;
  localparam cnt_t RST_MAX_MISS     = 8'd5;
  localparam cnt_t RST_OUTPOST_MISS = 8'd20;
  localparam us_t  RST_GAP_TIMEOUT  = 20'd100000;

  // Armor class codes used by the logic.
  localparam name_t NAME_THREE   = 3'd2;
  localparam name_t NAME_FOUR    = 3'd3;
  localparam name_t NAME_FIVE    = 3'd4;
  localparam name_t NAME_OUTPOST = 3'd6;
  localparam name_t NAME_BASE    = 3'd7;
  localparam logic  KIND_BIG     = 1'b1;

  // Filter initialisation profiles.
  localparam init_t INIT_BALANCE = 2'd0;
  localparam init_t INIT_OUTPOST = 2'd1;
  localparam init_t INIT_BASE    = 2'd2;
  localparam init_t INIT_OTHER   = 2'd3;

  // Increment that holds at the top of the range.
  function automatic cnt_t sat_inc(input cnt_t v);
    sat_inc = (v == 8'hFF) ? v : v + 8'd1;
  endfunction

  // Filter profile for a newly chosen target.
  function automatic init_t classify(input name_t name, input logic kind);
    if (kind == KIND_BIG &&
        (name == NAME_THREE || name == NAME_FOUR || name == NAME_FIVE)) begin
      classify = INIT_BALANCE;
    end else if (name == NAME_OUTPOST) begin
      classify = INIT_OUTPOST;
    end else if (name == NAME_BASE) begin
      classify = INIT_BASE;
    end else begin
      classify = INIT_OTHER;
    end
  endfunction

endpackage
`default_nettype wire

@@ rtl/target_acquire_track_state.sv @@
// A frame end passes through the input register, then the result register, and is
// then shown on the output; armor items give no result.
// Throughput: one item per cycle, limited only by the result register: a frame
// end waits in the input register while an earlier result is still stalled.
// Reset: asynchronous, active low; track state lost, per-frame candidate and
// counters cleared, configuration registers at their default values.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Target acquisition and track state
// Streams detected armors per frame, keeps the best candidate and the count of
// armors matching the held target, and runs the four-state track machine at
// each frame end.
// ----------------------------------------------------------------------------
module target_acquire_track_state #(
  parameter int unsigned MAX_ARMORS_PER_FRAME = tas_pkg::MaxArmorsPerFrame
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Configuration write channel.
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire tas_pkg::cfg_idx_t   cfg_index_i,
  input  wire tas_pkg::cfg_data_t  cfg_data_i,
  // Input item channel.
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic                op_i,
  input  wire logic                armor_color_i,
  input  wire tas_pkg::name_t      armor_name_i,
  input  wire logic                armor_size_i,
  input  wire tas_pkg::prio_t      armor_priority_i,
  input  wire tas_pkg::dist_t      center_distance_i,
  input  wire tas_pkg::us_t        elapsed_us_i,
  input  wire logic                filter_diverged_i,
  input  wire logic                nis_window_nonempty_i,
  input  wire tas_pkg::idx_t       nis_failures_i,
  input  wire tas_pkg::idx_t       nis_window_size_i,
  // Result channel.
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output tas_pkg::mode_t           track_state_o,
  output logic                     target_valid_o,
  output tas_pkg::name_t           target_name_o,
  output logic                     target_kind_o,
  output logic                     acquired_o,
  output tas_pkg::idx_t            chosen_index_o,
  output tas_pkg::init_t           init_class_o,
  output tas_pkg::idx_t            match_count_o
);
  import tas_pkg::*;

  localparam int unsigned ArrW = $clog2(MAX_ARMORS_PER_FRAME + 1);
  typedef logic [ArrW-1:0] arr_t;
  localparam arr_t ArrLimit = arr_t'(MAX_ARMORS_PER_FRAME);

  typedef enum logic [1:0] {
    MODE_LOST      = 2'd0,
    MODE_DETECTING = 2'd1,
    MODE_TRACKING  = 2'd2,
    MODE_TEMP_LOST = 2'd3
  } mode_e;

  // Configuration registers.
  logic  enemy_color_q;
  cnt_t  min_detect_q, max_miss_q, outpost_miss_q;
  us_t   gap_timeout_q;

  // Input register.
  logic  in_valid_q;
  logic  op_q, color_q, kind_q, diverged_q, nis_any_q;
  name_t name_q;
  prio_t prio_q;
  dist_t dist_q;
  us_t   elapsed_q;
  idx_t  nis_fail_q, nis_win_q;

  // Track state and per-frame state.
  mode_e mode_q, mode_d;
  cnt_t  detect_q, detect_d, miss_q, miss_d;
  name_t held_name_q, held_name_d;
  logic  held_kind_q, held_kind_d;
  logic  best_valid_q, best_valid_d;
  prio_t best_prio_q, best_prio_d;
  dist_t best_dist_q, best_dist_d;
  name_t best_name_q, best_name_d;
  logic  best_kind_q, best_kind_d;
  idx_t  best_slot_q, best_slot_d;
  idx_t  matches_q, matches_d;
  arr_t  arrival_q, arrival_d;

  // Result register.
  logic  out_valid_q, out_valid_d;
  mode_t res_state_q, res_state_d;
  logic  res_tvalid_q, res_tvalid_d;
  name_t res_name_q, res_name_d;
  logic  res_kind_q, res_kind_d;
  logic  res_acq_q, res_acq_d;
  idx_t  res_chosen_q, res_chosen_d;
  init_t res_init_q, res_init_d;
  idx_t  res_mcount_q, res_mcount_d;

  logic  advance, do_armor, do_frame;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enemy_color_q  <= RST_ENEMY_COLOR;
      min_detect_q   <= RST_MIN_DETECT;
      max_miss_q     <= RST_MAX_MISS;
      outpost_miss_q <= RST_OUTPOST_MISS;
      gap_timeout_q  <= RST_GAP_TIMEOUT;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_ENEMY_COLOR:  enemy_color_q  <= cfg_data_i[0];
        CFG_MIN_DETECT:   min_detect_q   <= cfg_data_i[7:0];
        CFG_MAX_MISS:     max_miss_q     <= cfg_data_i[7:0];
        CFG_OUTPOST_MISS: outpost_miss_q <= cfg_data_i[7:0];
        CFG_GAP_TIMEOUT:  gap_timeout_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // An armor always moves on; a frame end needs the result register free.
  assign advance    = (op_q == OP_ARMOR) || !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;
  assign do_armor   = in_valid_q && (op_q == OP_ARMOR);
  assign do_frame   = in_valid_q && (op_q == OP_FRAME_END) && advance;

  // Input register: loads on every transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      op_q       <= op_i;
      color_q    <= armor_color_i;
      name_q     <= armor_name_i;
      kind_q     <= armor_size_i;
      prio_q     <= armor_priority_i;
      dist_q     <= center_distance_i;
      elapsed_q  <= elapsed_us_i;
      diverged_q <= filter_diverged_i;
      nis_any_q  <= nis_window_nonempty_i;
      nis_fail_q <= nis_failures_i;
      nis_win_q  <= nis_window_size_i;
    end
  end

  // Armor and frame-end processing.
  always_comb begin
    mode_e mode_g;
    logic  match_path, found, better, nis_trip;
    cnt_t  det_inc, miss_inc, limit;
    logic  [8:0] fail_x5;
    logic  [6:0] win_x2;

    mode_d       = mode_q;
    detect_d     = detect_q;
    miss_d       = miss_q;
    held_name_d  = held_name_q;
    held_kind_d  = held_kind_q;
    best_valid_d = best_valid_q;
    best_prio_d  = best_prio_q;
    best_dist_d  = best_dist_q;
    best_name_d  = best_name_q;
    best_kind_d  = best_kind_q;
    best_slot_d  = best_slot_q;
    matches_d    = matches_q;
    arrival_d    = arrival_q;

    out_valid_d  = out_valid_q && out_stall_i;
    res_state_d  = res_state_q;
    res_tvalid_d = res_tvalid_q;
    res_name_d   = res_name_q;
    res_kind_d   = res_kind_q;
    res_acq_d    = res_acq_q;
    res_chosen_d = res_chosen_q;
    res_init_d   = res_init_q;
    res_mcount_d = res_mcount_q;

    // Gap check ahead of the decision.
    mode_g = mode_q;
    if (mode_q != MODE_LOST && elapsed_q > gap_timeout_q) begin
      mode_g = MODE_LOST;
    end
    match_path = (mode_g != MODE_LOST);
    found      = match_path ? (matches_q != '0) : best_valid_q;
    det_inc    = sat_inc(detect_q);
    miss_inc   = sat_inc(miss_q);
    limit      = (held_name_q == NAME_OUTPOST) ? outpost_miss_q : max_miss_q;
    better     = !best_valid_q || (prio_q < best_prio_q) ||
                 (prio_q == best_prio_q && dist_q < best_dist_q);
    // failures >= floor(2*window/5) rewritten without a divider.
    fail_x5    = 9'(nis_fail_q) * 9'd5 + 9'd4;
    win_x2     = {nis_win_q, 1'b0};
    nis_trip   = nis_any_q && (fail_x5 >= 9'(win_x2));

    if (do_armor) begin
      if (arrival_q < ArrLimit) begin
        arrival_d = arrival_q + arr_t'(1);
        if (color_q == enemy_color_q) begin
          if (better) begin
            best_valid_d = 1'b1;
            best_prio_d  = prio_q;
            best_dist_d  = dist_q;
            best_name_d  = name_q;
            best_kind_d  = kind_q;
            best_slot_d  = idx_t'(arrival_q);
          end
          if (name_q == held_name_q && kind_q == held_kind_q &&
              matches_q != 6'd63) begin
            matches_d = matches_q + 6'd1;
          end
        end
      end
    end else if (do_frame) begin
      res_acq_d    = 1'b0;
      res_chosen_d = '0;
      res_init_d   = INIT_BALANCE;
      res_mcount_d = match_path ? matches_q : '0;
      if (!match_path && found) begin
        held_name_d  = best_name_q;
        held_kind_d  = best_kind_q;
        res_acq_d    = 1'b1;
        res_chosen_d = best_slot_q;
        res_init_d   = classify(best_name_q, best_kind_q);
      end

      // Four-state track machine.
      mode_d = mode_g;
      unique case (mode_g)
        MODE_LOST: begin
          if (found) begin
            mode_d   = MODE_DETECTING;
            detect_d = 8'd1;
          end
        end
        MODE_DETECTING: begin
          if (found) begin
            detect_d = det_inc;
            if (det_inc >= min_detect_q) mode_d = MODE_TRACKING;
          end else begin
            detect_d = '0;
            mode_d   = MODE_LOST;
          end
        end
        MODE_TRACKING: begin
          if (!found) begin
            miss_d = 8'd1;
            mode_d = MODE_TEMP_LOST;
          end
        end
        MODE_TEMP_LOST: begin
          if (found) begin
            mode_d = MODE_TRACKING;
          end else begin
            miss_d = miss_inc;
            if (miss_inc > limit) mode_d = MODE_LOST;
          end
        end
        default: ;
      endcase

      // Filter health checks override the machine.
      if (diverged_q || nis_trip) mode_d = MODE_LOST;

      out_valid_d  = 1'b1;
      res_state_d  = mode_t'(mode_d);
      res_tvalid_d = (mode_d != MODE_LOST);
      res_name_d   = (mode_d != MODE_LOST) ? held_name_d : '0;
      res_kind_d   = (mode_d != MODE_LOST) && held_kind_d;

      // Start a fresh frame.
      best_valid_d = 1'b0;
      best_prio_d  = '0;
      best_dist_d  = '0;
      best_name_d  = '0;
      best_kind_d  = 1'b0;
      best_slot_d  = '0;
      matches_d    = '0;
      arrival_d    = '0;
    end
  end

  // State and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_LOST;
      detect_q     <= '0;
      miss_q       <= '0;
      held_name_q  <= '0;
      held_kind_q  <= 1'b0;
      best_valid_q <= 1'b0;
      best_prio_q  <= '0;
      best_dist_q  <= '0;
      best_name_q  <= '0;
      best_kind_q  <= 1'b0;
      best_slot_q  <= '0;
      matches_q    <= '0;
      arrival_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      mode_q       <= mode_d;
      detect_q     <= detect_d;
      miss_q       <= miss_d;
      held_name_q  <= held_name_d;
      held_kind_q  <= held_kind_d;
      best_valid_q <= best_valid_d;
      best_prio_q  <= best_prio_d;
      best_dist_q  <= best_dist_d;
      best_name_q  <= best_name_d;
      best_kind_q  <= best_kind_d;
      best_slot_q  <= best_slot_d;
      matches_q    <= matches_d;
      arrival_q    <= arrival_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_state_q  <= res_state_d;
    res_tvalid_q <= res_tvalid_d;
    res_name_q   <= res_name_d;
    res_kind_q   <= res_kind_d;
    res_acq_q    <= res_acq_d;
    res_chosen_q <= res_chosen_d;
    res_init_q   <= res_init_d;
    res_mcount_q <= res_mcount_d;
  end

  assign out_valid_o    = out_valid_q;
  assign track_state_o  = res_state_q;
  assign target_valid_o = res_tvalid_q;
  assign target_name_o  = res_name_q;
  assign target_kind_o  = res_kind_q;
  assign acquired_o     = res_acq_q;
  assign chosen_index_o = res_chosen_q;
  assign init_class_o   = res_init_q;
  assign match_count_o  = res_mcount_q;

endmodule
`default_nettype wire

@@ tb/target_acquire_track_state_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Target acquisition and track state: testbench
// Streams armor and frame-end transfers into the block, predicts every frame
// report with an independent model of the track machine and compares each
// result transfer field by field, under random idling on both channels.
// ----------------------------------------------------------------------------
module target_acquire_track_state_tb;
  import tas_pkg::*;

  localparam int unsigned CLK_PERIOD       = 10;
  localparam int unsigned RESET_CYCLES     = 6;
  localparam int unsigned DRAIN_CYCLES     = 4;
  localparam int unsigned LONG_HOLD_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT      = 400000;
  localparam int unsigned ARMOR_LIMIT      = MaxArmorsPerFrame;
  localparam int unsigned RANDOM_PHASES    = 6;
  localparam int unsigned FRAMES_PER_PHASE = 40;

  // Track states.
  localparam mode_t MODE_LOST      = 2'd0;
  localparam mode_t MODE_DETECTING = 2'd1;
  localparam mode_t MODE_TRACKING  = 2'd2;
  localparam mode_t MODE_TEMP_LOST = 2'd3;

  // Codes that the package does not name.
  localparam logic  COLOR_RED   = 1'b0;
  localparam logic  COLOR_BLUE  = 1'b1;
  localparam logic  KIND_SMALL  = 1'b0;
  localparam name_t NAME_ONE    = 3'd0;
  localparam name_t NAME_TWO    = 3'd1;
  localparam name_t NAME_SENTRY = 3'd5;

  // One input transfer, armor or frame end.
  typedef struct packed {
    logic  op;
    logic  color;
    name_t name;
    logic  kind;
    prio_t prio;
    dist_t distance;
    us_t   elapsed;
    logic  diverged;
    logic  nis_any;
    idx_t  nis_fail;
    idx_t  nis_win;
  } detection_t;

  // One frame report.
  typedef struct packed {
    mode_t state;
    logic  tracked;
    name_t name;
    logic  kind;
    logic  is_new;
    idx_t  chosen;
    init_t profile;
    idx_t  hits;
  } track_report_t;

  logic clk = 1'b0;
  logic rst_n;

  logic      cfg_valid;
  logic      cfg_ready;
  cfg_idx_t  cfg_index;
  cfg_data_t cfg_data;

  logic  in_valid;
  logic  in_stall;
  logic  op;
  logic  armor_color;
  name_t armor_name;
  logic  armor_size;
  prio_t armor_priority;
  dist_t center_distance;
  us_t   elapsed_us;
  logic  filter_diverged;
  logic  nis_window_nonempty;
  idx_t  nis_failures;
  idx_t  nis_window_size;

  logic  out_valid;
  logic  out_stall;
  mode_t track_state;
  logic  target_valid;
  name_t target_name;
  logic  target_kind;
  logic  acquired;
  idx_t  chosen_index;
  init_t init_class;
  idx_t  match_count;

  // Test control shared between processes.
  logic        tx_idle_on    = 1'b1;
  logic        rx_idle_on    = 1'b1;
  logic        long_hold_req = 1'b0;
  int unsigned fail_count    = 0;
  int unsigned cycle_count   = 0;

  // Predicted reports, oldest first.
  track_report_t expected_reports[$];

  // Predictor copy of the configuration.
  logic keep_color         = RST_ENEMY_COLOR;
  cnt_t detect_need        = RST_MIN_DETECT;
  cnt_t miss_allow         = RST_MAX_MISS;
  cnt_t outpost_miss_allow = RST_OUTPOST_MISS;
  us_t  gap_limit_us       = RST_GAP_TIMEOUT;

  // Predictor copy of the track state and the per-frame candidate.
  mode_t       track_mode = MODE_LOST;
  cnt_t        detect_run = '0;
  cnt_t        miss_run   = '0;
  name_t       held_name  = '0;
  logic        held_kind  = 1'b0;
  logic        cand_valid = 1'b0;
  prio_t       cand_prio  = '0;
  dist_t       cand_dist  = '0;
  name_t       cand_name  = '0;
  logic        cand_kind  = 1'b0;
  idx_t        cand_slot  = '0;
  idx_t        match_seen = '0;
  int unsigned arrivals   = 0;

  target_acquire_track_state dut (
    .clk_i                 (clk),
    .rst_ni                (rst_n),
    .cfg_valid_i           (cfg_valid),
    .cfg_ready_o           (cfg_ready),
    .cfg_index_i           (cfg_index),
    .cfg_data_i            (cfg_data),
    .in_valid_i            (in_valid),
    .in_stall_o            (in_stall),
    .op_i                  (op),
    .armor_color_i         (armor_color),
    .armor_name_i          (armor_name),
    .armor_size_i          (armor_size),
    .armor_priority_i      (armor_priority),
    .center_distance_i     (center_distance),
    .elapsed_us_i          (elapsed_us),
    .filter_diverged_i     (filter_diverged),
    .nis_window_nonempty_i (nis_window_nonempty),
    .nis_failures_i        (nis_failures),
    .nis_window_size_i     (nis_window_size),
    .out_valid_o           (out_valid),
    .out_stall_i           (out_stall),
    .track_state_o         (track_state),
    .target_valid_o        (target_valid),
    .target_name_o         (target_name),
    .target_kind_o         (target_kind),
    .acquired_o            (acquired),
    .chosen_index_o        (chosen_index),
    .init_class_o          (init_class),
    .match_count_o         (match_count)
  );

  // Free-running clock.
  always #(CLK_PERIOD / 2) clk = ~clk;

  // Filter profile of a freshly chosen target.
  function automatic init_t filter_profile(input name_t name, input logic kind);
    if (kind == KIND_BIG && (name == NAME_THREE || name == NAME_FOUR || name == NAME_FIVE)) begin
      return INIT_BALANCE;
    end
    if (name == NAME_OUTPOST) begin
      return INIT_OUTPOST;
    end
    if (name == NAME_BASE) begin
      return INIT_BASE;
    end
    return INIT_OTHER;
  endfunction

  // Register write as seen by the predictor: each register keeps its own width.
  function automatic void apply_setting(input cfg_idx_t index, input cfg_data_t value);
    case (index)
      CFG_ENEMY_COLOR:  keep_color = value[0];
      CFG_MIN_DETECT:   detect_need = value[7:0];
      CFG_MAX_MISS:     miss_allow = value[7:0];
      CFG_OUTPOST_MISS: outpost_miss_allow = value[7:0];
      CFG_GAP_TIMEOUT:  gap_limit_us = value[19:0];
      default: ;
    endcase
  endfunction

  // An armor updates the running best candidate and the match count.
  task automatic predict_armor(input detection_t d);
    idx_t slot;
    if (arrivals >= ARMOR_LIMIT) begin
      return;
    end
    slot = idx_t'(arrivals);
    arrivals++;
    if (d.color != keep_color) begin
      return;
    end
    if (!cand_valid || d.prio < cand_prio ||
        (d.prio == cand_prio && d.distance < cand_dist)) begin
      cand_valid = 1'b1;
      cand_prio  = d.prio;
      cand_dist  = d.distance;
      cand_name  = d.name;
      cand_kind  = d.kind;
      cand_slot  = slot;
    end
    if (d.name == held_name && d.kind == held_kind && match_seen != 6'd63) begin
      match_seen++;
    end
  endtask

  // A frame end runs the gap check, the decision, the state machine and the
  // health checks, then queues the report it produces.
  task automatic predict_frame_end(input detection_t d);
    track_report_t rep;
    logic          found;
    cnt_t          miss_cap;
    idx_t          nis_floor;
    rep = '0;
    if (track_mode != MODE_LOST && d.elapsed > gap_limit_us) begin
      track_mode = MODE_LOST;
    end
    if (track_mode == MODE_LOST) begin
      found = cand_valid;
      if (found) begin
        held_name   = cand_name;
        held_kind   = cand_kind;
        rep.is_new  = 1'b1;
        rep.chosen  = cand_slot;
        rep.profile = filter_profile(cand_name, cand_kind);
      end
    end else begin
      found    = (match_seen != '0);
      rep.hits = match_seen;
    end
    case (track_mode)
      MODE_LOST: begin
        if (found) begin
          track_mode = MODE_DETECTING;
          detect_run = 8'd1;
        end
      end
      MODE_DETECTING: begin
        if (found) begin
          if (detect_run != 8'hFF) begin
            detect_run++;
          end
          if (detect_run >= detect_need) begin
            track_mode = MODE_TRACKING;
          end
        end else begin
          detect_run = '0;
          track_mode = MODE_LOST;
        end
      end
      MODE_TRACKING: begin
        if (!found) begin
          miss_run   = 8'd1;
          track_mode = MODE_TEMP_LOST;
        end
      end
      default: begin
        if (found) begin
          track_mode = MODE_TRACKING;
        end else begin
          if (miss_run != 8'hFF) begin
            miss_run++;
          end
          miss_cap = (held_name == NAME_OUTPOST) ? outpost_miss_allow : miss_allow;
          if (miss_run > miss_cap) begin
            track_mode = MODE_LOST;
          end
        end
      end
    endcase
    // Health checks after the machine.
    nis_floor = idx_t'((2 * int'(d.nis_win)) / 5);
    if (track_mode != MODE_LOST && d.diverged) begin
      track_mode = MODE_LOST;
    end
    if (track_mode != MODE_LOST && d.nis_any && d.nis_fail >= nis_floor) begin
      track_mode = MODE_LOST;
    end
    rep.state   = track_mode;
    rep.tracked = (track_mode != MODE_LOST);
    if (rep.tracked) begin
      rep.name = held_name;
      rep.kind = held_kind;
    end
    expected_reports.push_back(rep);
    // The per-frame candidate starts afresh.
    cand_valid = 1'b0;
    cand_prio  = '0;
    cand_dist  = '0;
    cand_name  = '0;
    cand_kind  = 1'b0;
    cand_slot  = '0;
    match_seen = '0;
    arrivals   = 0;
  endtask

  // Every field random, unused ones included.
  function automatic detection_t random_detection();
    logic [63:0] bits;
    bits = {$urandom, $urandom};
    return bits[$bits(detection_t)-1:0];
  endfunction

  function automatic detection_t armor(input logic color, input name_t name, input logic kind,
                                       input prio_t prio, input dist_t distance);
    detection_t d;
    d          = random_detection();
    d.op       = OP_ARMOR;
    d.color    = color;
    d.name     = name;
    d.kind     = kind;
    d.prio     = prio;
    d.distance = distance;
    return d;
  endfunction

  function automatic detection_t frame_end(input us_t elapsed, input logic diverged,
                                           input logic nis_any, input idx_t nis_fail,
                                           input idx_t nis_win);
    detection_t d;
    d          = random_detection();
    d.op       = OP_FRAME_END;
    d.elapsed  = elapsed;
    d.diverged = diverged;
    d.nis_any  = nis_any;
    d.nis_fail = nis_fail;
    d.nis_win  = nis_win;
    return d;
  endfunction

  // Offers one item, with an optional idle burst first, and predicts it once
  // the transfer has taken place. Valid stays high for a following item.
  task automatic send_item(input detection_t d);
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid            <= 1'b1;
    op                  <= d.op;
    armor_color         <= d.color;
    armor_name          <= d.name;
    armor_size          <= d.kind;
    armor_priority      <= d.prio;
    center_distance     <= d.distance;
    elapsed_us          <= d.elapsed;
    filter_diverged     <= d.diverged;
    nis_window_nonempty <= d.nis_any;
    nis_failures        <= d.nis_fail;
    nis_window_size     <= d.nis_win;
    do @(posedge clk); while (in_stall);
    if (d.op == OP_ARMOR) begin
      predict_armor(d);
    end else begin
      predict_frame_end(d);
    end
  endtask

  // Stops offering and waits until every report has arrived and the block has
  // had time to finish any armor still in flight.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes all five registers back to back; unused upper data bits are random.
  task automatic write_settings(input logic color, input cnt_t min_detect, input cnt_t max_miss,
                                input cnt_t outpost_miss, input us_t gap);
    cfg_idx_t  reg_index[5];
    cfg_data_t reg_value[5];
    reg_index = '{CFG_ENEMY_COLOR, CFG_MIN_DETECT, CFG_MAX_MISS, CFG_OUTPOST_MISS,
                  CFG_GAP_TIMEOUT};
    for (int i = 0; i < 5; i++) begin
      reg_value[i] = cfg_data_t'($urandom);
    end
    reg_value[0][0]   = color;
    reg_value[1][7:0] = min_detect;
    reg_value[2][7:0] = max_miss;
    reg_value[3][7:0] = outpost_miss;
    reg_value[4]      = gap;
    for (int i = 0; i < 5; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= reg_index[i];
      cfg_data  <= reg_value[i];
      do @(posedge clk); while (!cfg_ready);
      apply_setting(reg_index[i], reg_value[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  // A well-formed frame with random content: mostly kept armors, many of them
  // matching the held target, then a frame end that mostly keeps the track.
  task automatic random_frame(input int unsigned max_armors);
    detection_t  d;
    int unsigned count;
    count = $urandom_range(0, max_armors);
    repeat (count) begin
      d    = random_detection();
      d.op = OP_ARMOR;
      if ($urandom_range(0, 9) < 8) begin
        d.color = keep_color;
      end
      if ($urandom_range(0, 9) < 5) begin
        d.name = held_name;
        d.kind = held_kind;
      end
      if ($urandom_range(0, 1) == 0) begin
        d.prio = prio_t'($urandom_range(0, 2));
      end
      if ($urandom_range(0, 2) == 0) begin
        d.distance = dist_t'($urandom_range(0, 3));
      end
      send_item(d);
    end
    d    = random_detection();
    d.op = OP_FRAME_END;
    case ($urandom_range(0, 9))
      0:       d.elapsed = us_t'($urandom);
      1:       d.elapsed = gap_limit_us + 20'd1;
      2:       d.elapsed = gap_limit_us;
      default: d.elapsed = us_t'($urandom_range(0, 32'(gap_limit_us)));
    endcase
    d.diverged = ($urandom_range(0, 24) == 0);
    if ($urandom_range(0, 7) != 0) begin
      d.nis_win  = idx_t'($urandom_range(3, 63));
      d.nis_fail = idx_t'($urandom_range(0, (2 * int'(d.nis_win)) / 5 - 1));
    end
    send_item(d);
  endtask

  // Selection order, dropped colours, detecting to tracking, a miss, the gap
  // check at and above the timeout, and the outpost, balance and other filter profiles.
  task automatic test_acquire_and_track();
    send_item(armor(COLOR_RED, NAME_THREE, KIND_BIG, 4'd5, 16'd100));
    send_item(armor(COLOR_BLUE, NAME_ONE, KIND_SMALL, 4'd0, 16'd0));
    send_item(armor(COLOR_RED, NAME_OUTPOST, KIND_SMALL, 4'd5, 16'd50));
    send_item(armor(COLOR_RED, NAME_BASE, KIND_BIG, 4'd5, 16'd50));
    send_item(armor(COLOR_RED, NAME_TWO, KIND_SMALL, 4'hF, 16'hFFFF));
    send_item(frame_end('0, 1'b0, 1'b0, '0, '0));
    send_item(armor(COLOR_RED, NAME_OUTPOST, KIND_SMALL, 4'hF, 16'hFFFF));
    send_item(armor(COLOR_RED, NAME_OUTPOST, KIND_BIG, 4'd0, 16'd0));
    send_item(armor(COLOR_RED, NAME_OUTPOST, KIND_SMALL, 4'd0, 16'd0));
    send_item(frame_end(RST_GAP_TIMEOUT, 1'b0, 1'b0, '0, '0));
    send_item(armor(COLOR_RED, NAME_OUTPOST, KIND_SMALL, 4'd3, 16'd9));
    send_item(frame_end('0, 1'b0, 1'b0, '0, '0));
    send_item(frame_end('0, 1'b0, 1'b0, '0, '0));
    send_item(frame_end(20'hFFFFF, 1'b0, 1'b0, '0, '0));
    send_item(armor(COLOR_RED, NAME_FOUR, KIND_BIG, 4'd0, 16'd7));
    send_item(frame_end('0, 1'b0, 1'b0, '0, '0));
    send_item(frame_end(RST_GAP_TIMEOUT + 20'd1, 1'b0, 1'b0, '0, '0));
    send_item(armor(COLOR_RED, NAME_SENTRY, KIND_SMALL, 4'd1, 16'd1));
    send_item(frame_end('0, 1'b0, 1'b0, '0, '0));
  endtask

  // Divergence and NIS failures, including a target that is chosen and lost in
  // the same frame, and the window of size zero.
  task automatic test_filter_health();
    send_item(frame_end('0, 1'b1, 1'b0, '0, '0));
    send_item(armor(COLOR_RED, NAME_BASE, KIND_SMALL, 4'd3, 16'd3));
    send_item(frame_end('0, 1'b1, 1'b0, '0, '0));
    send_item(armor(COLOR_RED, NAME_ONE, KIND_SMALL, 4'd3, 16'd3));
    send_item(frame_end('0, 1'b0, 1'b1, '0, '0));
    send_item(armor(COLOR_RED, NAME_ONE, KIND_SMALL, 4'd3, 16'd3));
    send_item(frame_end('0, 1'b0, 1'b1, 6'd24, 6'd63));
    send_item(armor(COLOR_RED, NAME_ONE, KIND_SMALL, 4'd3, 16'd3));
    send_item(frame_end('0, 1'b0, 1'b1, 6'd25, 6'd63));
    send_item(frame_end('0, 1'b0, 1'b1, 6'd63, 6'd63));
    send_item(armor(COLOR_RED, NAME_ONE, KIND_SMALL, 4'd3, 16'd3));
    send_item(frame_end('0, 1'b0, 1'b1, 6'd0, 6'd0));
  endtask

  // More armors than a frame takes: the last one counted wins, and the later
  // ones, better though they are, are ignored.
  task automatic test_frame_overflow();
    send_item(frame_end('0, 1'b1, 1'b0, '0, '0));
    for (int i = 0; i < ARMOR_LIMIT + 6; i++) begin
      if (i < ARMOR_LIMIT) begin
        send_item(armor(COLOR_RED, NAME_TWO, KIND_SMALL, 4'd1, dist_t'(1000 - i)));
      end else begin
        send_item(armor(COLOR_RED, NAME_BASE, KIND_BIG, 4'd0, 16'd0));
      end
    end
    send_item(frame_end('0, 1'b0, 1'b0, '0, '0));
  endtask

  // A miss limit at the top of the range never expires: the miss count holds
  // at its maximum.
  task automatic test_miss_saturation();
    wait_idle();
    write_settings(COLOR_BLUE, 8'd1, 8'hFF, 8'hFF, 20'hFFFFF);
    send_item(frame_end('0, 1'b1, 1'b0, '0, '0));
    repeat (2) begin
      send_item(armor(COLOR_BLUE, NAME_TWO, KIND_SMALL, 4'd0, 16'd0));
      send_item(frame_end('0, 1'b0, 1'b0, '0, '0));
    end
    repeat (258) send_item(frame_end('0, 1'b0, 1'b0, '0, '0));
    send_item(armor(COLOR_BLUE, NAME_TWO, KIND_SMALL, 4'd0, 16'd0));
    send_item(frame_end('0, 1'b0, 1'b0, '0, '0));
  endtask

  // Random frames under several settings, the extremes among them.
  task automatic test_random_phases();
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_idle();
      case (phase)
        0: write_settings(COLOR_BLUE, 8'd1, 8'd0, 8'd0, '0);
        1: write_settings(COLOR_RED, 8'hFF, 8'hFF, 8'hFF, 20'hFFFFF);
        2: write_settings(RST_ENEMY_COLOR, RST_MIN_DETECT, RST_MAX_MISS, RST_OUTPOST_MISS,
                          RST_GAP_TIMEOUT);
        default: write_settings(1'($urandom_range(0, 1)), cnt_t'($urandom_range(1, 4)),
                                cnt_t'($urandom_range(0, 6)), cnt_t'($urandom_range(0, 8)),
                                us_t'($urandom_range(1000, 20'hFFFFF)));
      endcase
      repeat (FRAMES_PER_PHASE) random_frame(5);
    end
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering,
  // so that the block fills up and stalls its input.
  task automatic test_long_hold();
    tx_idle_on    = 1'b0;
    long_hold_req = 1'b1;
    repeat (30) random_frame(4);
    wait_idle();
    tx_idle_on = 1'b1;
  endtask

  // Closing stretch with no idling on either side.
  task automatic test_calm_finish();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    repeat (20) random_frame(5);
  endtask

  // Result stall: random bursts, free stretches and the long hold on request.
  initial begin : result_backpressure
    forever begin
      if (long_hold_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold_req = 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
    end
  end

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
      fail_count++;
    end
  endtask

  // Each result transfer is compared with the oldest prediction.
  always @(posedge clk) begin : report_checker
    track_report_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_reports.size() == 0) begin
        $error("Result transfer with no report predicted: track_state %0d", track_state);
        fail_count++;
      end else begin
        want = expected_reports.pop_front();
        check_field("track_state", 32'(want.state), 32'(track_state));
        check_field("target_valid", 32'(want.tracked), 32'(target_valid));
        check_field("target_name", 32'(want.name), 32'(target_name));
        check_field("target_kind", 32'(want.kind), 32'(target_kind));
        check_field("acquired", 32'(want.is_new), 32'(acquired));
        check_field("chosen_index", 32'(want.chosen), 32'(chosen_index));
        check_field("init_class", 32'(want.profile), 32'(init_class));
        check_field("match_count", 32'(want.hits), 32'(match_count));
      end
    end
  end

  // Run limit.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  // Test sequence.
  initial begin : test_sequence
    rst_n               = 1'b0;
    cfg_valid           <= 1'b0;
    cfg_index           <= '0;
    cfg_data            <= '0;
    in_valid            <= 1'b0;
    op                  <= OP_ARMOR;
    armor_color         <= 1'b0;
    armor_name          <= '0;
    armor_size          <= 1'b0;
    armor_priority      <= '0;
    center_distance     <= '0;
    elapsed_us          <= '0;
    filter_diverged     <= 1'b0;
    nis_window_nonempty <= 1'b0;
    nis_failures        <= '0;
    nis_window_size     <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_acquire_and_track();
    test_filter_health();
    test_frame_overflow();
    test_miss_saturation();
    test_random_phases();
    test_long_hold();
    test_calm_finish();
    wait_idle();

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
